### rtl/core/ckrb_pkg.sv
// package for the color keyed rectangle blitter
// register indexes, field widths and the stage payload type; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ckrb_pkg;

  localparam int DIM_W   = 13;
  localparam int POS_W   = 12;
  localparam int PIX_W   = 32;
  localparam int IDX_W   = 24;
  localparam int MODE_W  = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int MODE_SIXTEEN = 0;
  localparam int MODE_FLIP    = 1;
  localparam int MODE_KEYED   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURFACE_WIDTH  = 3'd0,
    REG_SURFACE_HEIGHT = 3'd1,
    REG_RECT_X         = 3'd2,
    REG_RECT_Y         = 3'd3,
    REG_RECT_W         = 3'd4,
    REG_RECT_H         = 3'd5,
    REG_MODE           = 3'd6,
    REG_COLOR_KEY      = 3'd7
  } cfg_reg_t;

  localparam logic [DIM_W-1:0]  SURFACE_WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]  SURFACE_HEIGHT_RST = 13'd480;
  localparam logic [DIM_W-1:0]  RECT_SIDE_RST      = 13'd1;
  localparam logic [MODE_W-1:0] MODE_RST           = 3'd2;

  // address stage result, consumed by the index stage
  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic [PIX_W-1:0] pixel;
    logic             out_of_range;
    logic             write_enable;
    logic             last_pixel;
  } stage_t;

endpackage

`default_nettype wire

### rtl/core/ckrb_if.sv
// stream interfaces of the color keyed rectangle blitter
// source pixel channel and result channel; depends on ckrb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ckrb_pix_if import ckrb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface ckrb_res_if import ckrb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] write_index;
  logic [PIX_W-1:0] pixel_out;
  logic             write_enable;
  logic             out_of_range;
  logic             last_pixel;

  modport source (output valid, output write_index, output pixel_out, output write_enable,
                  output out_of_range, output last_pixel, input ready);
  modport sink   (input valid, input write_index, input pixel_out, input write_enable,
                  input out_of_range, input last_pixel, output ready);
endinterface

`default_nettype wire

### rtl/core/color_keyed_rect_blit_top.sv
// color keyed rectangle blitter, top level
// depends on ckrb_pkg and the stream interfaces in ckrb_if
// pipeline: a pixel transaction is registered in the address stage, then in the index stage, before its result
// throughput: 1 pixel per cycle unless results.ready stalls; the index stage holds one 13 x 13 multiply
// reset: synchronous; registers return to their defaults, walk counters and
// the valid flags of both pipeline stages are cleared
`timescale 1ns / 1ps
`default_nettype none

module color_keyed_rect_blit_top import ckrb_pkg::*; #(
  parameter int MAX_SIDE = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  ckrb_pix_if.sink                   pixels,
  ckrb_res_if.source                 results
);

  localparam int CNT_W  = $clog2(MAX_SIDE);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CMP_W  = (SIDE_W > DIM_W) ? SIDE_W : DIM_W;
  localparam int SUM_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int SR_W   = SUM_W + 2;

  // configuration
  logic [DIM_W-1:0]  surface_width;
  logic [DIM_W-1:0]  surface_height;
  logic [POS_W-1:0]  rect_x;
  logic [POS_W-1:0]  rect_y;
  logic [DIM_W-1:0]  rect_w;
  logic [DIM_W-1:0]  rect_h;
  logic [MODE_W-1:0] mode;
  logic [PIX_W-1:0]  color_key;

  logic [CNT_W-1:0]  col_cnt;
  logic [CNT_W-1:0]  row_cnt;

  logic              s1_valid;
  stage_t            s1;
  stage_t            s1_next;
  logic              res_valid;

  logic              accept;
  logic              advance;

  logic [CMP_W-1:0]  w_side;
  logic [CMP_W-1:0]  h_side;
  logic              col_wrap;
  logic              row_wrap;
  logic [SUM_W-1:0]  col_sum;
  logic [SUM_W-1:0]  row_sum;
  logic [SR_W-1:0]   flip_row;
  logic [SR_W-1:0]   row_eff;
  logic              row_neg;
  logic              sixteen;
  logic              oor;
  logic              skip;
  logic [PIX_W-1:0]  pix;
  logic [2*DIM_W-1:0] idx_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      surface_width  <= SURFACE_WIDTH_RST;
      surface_height <= SURFACE_HEIGHT_RST;
      rect_x         <= '0;
      rect_y         <= '0;
      rect_w         <= RECT_SIDE_RST;
      rect_h         <= RECT_SIDE_RST;
      mode           <= MODE_RST;
      color_key      <= '0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SURFACE_WIDTH:  surface_width  <= cfg_data[DIM_W-1:0];
        REG_SURFACE_HEIGHT: surface_height <= cfg_data[DIM_W-1:0];
        REG_RECT_X:         rect_x         <= cfg_data[POS_W-1:0];
        REG_RECT_Y:         rect_y         <= cfg_data[POS_W-1:0];
        REG_RECT_W:         rect_w         <= cfg_data[DIM_W-1:0];
        REG_RECT_H:         rect_h         <= cfg_data[DIM_W-1:0];
        REG_MODE:           mode           <= cfg_data[MODE_W-1:0];
        REG_COLOR_KEY:      color_key      <= cfg_data[PIX_W-1:0];
        default:            color_key      <= color_key;
      endcase
    end
  end

  // side clamp to 1 .. MAX_SIDE
  always_comb begin
    w_side = CMP_W'(rect_w);
    h_side = CMP_W'(rect_h);
    if (w_side == '0) w_side = CMP_W'(1);
    if (h_side == '0) h_side = CMP_W'(1);
    if (w_side > CMP_W'(MAX_SIDE)) w_side = CMP_W'(MAX_SIDE);
    if (h_side > CMP_W'(MAX_SIDE)) h_side = CMP_W'(MAX_SIDE);
  end

  assign col_wrap = (CMP_W'(col_cnt) + CMP_W'(1)) >= w_side;
  assign row_wrap = (CMP_W'(row_cnt) + CMP_W'(1)) >= h_side;

  assign advance = !res_valid || results.ready;
  assign pixels.ready = !s1_valid || advance;
  assign accept = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        col_cnt <= '0;
        row_cnt <= row_wrap ? '0 : row_cnt + CNT_W'(1);
      end else begin
        col_cnt <= col_cnt + CNT_W'(1);
      end
    end
  end

  // address stage
  assign sixteen  = mode[MODE_SIXTEEN];
  assign col_sum  = SUM_W'(rect_x) + SUM_W'(col_cnt);
  assign row_sum  = SUM_W'(rect_y) + SUM_W'(row_cnt);
  assign flip_row = SR_W'(surface_height) - SR_W'(1) - SR_W'(row_sum);
  assign row_eff  = mode[MODE_FLIP] ? flip_row : SR_W'(row_sum);
  assign row_neg  = mode[MODE_FLIP] && flip_row[SR_W-1];
  assign pix      = sixteen ? {16'h0000, pixels.pixel_in[15:0]} : pixels.pixel_in;
  assign oor      = row_neg || (row_eff >= SR_W'(surface_height))
                    || (SR_W'(col_sum) >= SR_W'(surface_width));
  assign skip     = mode[MODE_KEYED] && !sixteen && (pix == color_key);

  always_comb begin
    s1_next.row          = row_eff[DIM_W-1:0];
    s1_next.col          = col_sum[DIM_W-1:0];
    s1_next.pixel        = pix;
    s1_next.out_of_range = oor;
    s1_next.write_enable = !oor && !skip;
    s1_next.last_pixel   = col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixels.ready) begin
      s1_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // index stage
  assign idx_full = (2*DIM_W)'(s1.row) * (2*DIM_W)'(surface_width) + (2*DIM_W)'(s1.col);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      results.write_index  <= s1.out_of_range ? '0 : idx_full[IDX_W-1:0];
      results.pixel_out    <= s1.pixel;
      results.write_enable <= s1.write_enable;
      results.out_of_range <= s1.out_of_range;
      results.last_pixel   <= s1.last_pixel;
    end
  end

  assign results.valid = res_valid;

  a_oor_no_write: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.out_of_range |-> !results.write_enable && results.write_index == '0)
    else $error("out of range result marked for write");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(col_cnt) < w_side && CMP_W'(row_cnt) < h_side)
    else $error("walk counter beyond rectangle");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> col_cnt == '0 && row_cnt == '0)
    else $error("walk counters not restarted by register write");

endmodule

`default_nettype wire
